// ----- hdl/lcdtb_pkg.sv -----
`default_nettype none

package lcdtb_pkg;

    // Input kinds
    localparam logic [2:0] KIND_CMD    = 3'd0;
    localparam logic [2:0] KIND_DATA   = 3'd1;
    localparam logic [2:0] KIND_CHAR   = 3'd2;
    localparam logic [2:0] KIND_SETPOS = 3'd3;
    localparam logic [2:0] KIND_INIT   = 3'd4;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_CONTRAST   = 2'd0;
    localparam logic [1:0] REG_TEMP_COEFF = 2'd1;
    localparam logic [1:0] REG_BIAS       = 2'd2;

    localparam int PADDR_W = 4;

    localparam logic [7:0] CONTRAST_RST   = 8'd177;
    localparam logic [2:0] TEMP_COEFF_RST = 3'd4;
    localparam logic [4:0] BIAS_RST       = 5'd20;

    // Fixed command bytes
    localparam logic [7:0] CMD_EXTENDED = 8'h21;
    localparam logic [7:0] CMD_BASIC    = 8'h20;
    localparam logic [7:0] CMD_NORMAL   = 8'h0C;
    localparam logic [7:0] CMD_SET_X    = 8'h80;
    localparam logic [7:0] CMD_SET_Y    = 8'h40;

    localparam logic [7:0] CHAR_FIRST = 8'h20;
    localparam logic [7:0] CHAR_LAST  = 8'h7E;

    localparam int COLUMNS_DEF     = 84;
    localparam int BANKS_DEF       = 6;
    localparam int GLYPH_WIDTH_DEF = 5;

    localparam int FONT_COLS   = 5;
    localparam int FONT_CHARS  = 95;
    localparam int STEP_W      = 4;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;
    localparam int Q_CNT_W     = 2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
    } in_item_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] out_byte;
        logic       last;
        logic [6:0] cursor_x;
        logic [2:0] cursor_y;
    } out_item_t;

    typedef struct packed {
        logic [7:0] contrast;
        logic [2:0] temp_coeff;
        logic [4:0] bias;
    } cfg_t;

    // One classified item waiting for the back end
    typedef struct packed {
        logic [2:0]        kind;
        logic [STEP_W-1:0] last_step;
        logic [7:0]        data;
        logic [2:0]        bank;
        logic [39:0]       glyph;
    } desc_t;

    // Glyph rows, leftmost column in the top byte
    localparam logic [39:0] FONT [FONT_CHARS] = '{
        40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
        40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
        40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
        40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
        40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
        40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
        40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
        40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
        40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
        40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
        40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
        40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
        40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
        40'h00007f0000, 40'h0041360800, 40'h0000000000
    };

    function automatic logic [39:0] font_row(input logic [6:0] idx);
        logic [39:0] row;
        row = '0;
        if (idx < 7'(FONT_CHARS))
        begin
            row = FONT[idx];
        end
        return row;
    endfunction

    // Column of a glyph row; columns past the font width are blank
    function automatic logic [7:0] glyph_col(input logic [39:0] row,
                                             input logic [STEP_W-1:0] col);
        logic [7:0] b;
        case (col)
            4'd0:    b = row[39:32];
            4'd1:    b = row[31:24];
            4'd2:    b = row[23:16];
            4'd3:    b = row[15:8];
            4'd4:    b = row[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/lcdtb_regs.sv -----
`default_nettype none

module lcdtb_regs
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lcdtb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output lcdtb_pkg::cfg_t                  cfg
);
    import lcdtb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_CONTRAST:   cfg_next.contrast   = pwdata[7:0];
                REG_TEMP_COEFF: cfg_next.temp_coeff = pwdata[2:0];
                REG_BIAS:       cfg_next.bias       = pwdata[4:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_CONTRAST:   prdata = {24'd0, cfg_reg.contrast};
            REG_TEMP_COEFF: prdata = {29'd0, cfg_reg.temp_coeff};
            REG_BIAS:       prdata = {27'd0, cfg_reg.bias};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.contrast   <= CONTRAST_RST;
            cfg_reg.temp_coeff <= TEMP_COEFF_RST;
            cfg_reg.bias       <= BIAS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/lcdtb_front.sv -----
`default_nettype none

module lcdtb_front
#(
    parameter int COLUMNS     = lcdtb_pkg::COLUMNS_DEF,
    parameter int BANKS       = lcdtb_pkg::BANKS_DEF,
    parameter int GLYPH_WIDTH = lcdtb_pkg::GLYPH_WIDTH_DEF
)
(
    input  wire logic                 host_valid,
    input  wire lcdtb_pkg::in_item_t  host_item,
    input  wire logic                 q_full,
    output logic                      host_stall,
    output logic                      push,
    output lcdtb_pkg::desc_t          desc
);
    import lcdtb_pkg::*;

    localparam logic [7:0] MAX_X = 8'(COLUMNS - 1);
    localparam logic [7:0] MAX_Y = 8'(BANKS - 1);
    localparam logic [STEP_W-1:0] CHAR_LAST_STEP = STEP_W'(GLYPH_WIDTH);

    logic       printable;
    logic       known;
    logic [6:0] glyph_idx;
    logic [7:0] x_clamped;

    assign host_stall = q_full;

    assign printable = (host_item.value >= CHAR_FIRST) && (host_item.value <= CHAR_LAST);
    assign glyph_idx = 7'(host_item.value - CHAR_FIRST);
    assign x_clamped = (host_item.pos_x > MAX_X) ? MAX_X : host_item.pos_x;

    // Unknown kinds are taken and dropped
    always_comb
    begin
        desc.kind      = host_item.kind;
        desc.data      = host_item.value;
        desc.bank      = (host_item.pos_y > MAX_Y) ? MAX_Y[2:0] : host_item.pos_y[2:0];
        desc.glyph     = printable ? font_row(glyph_idx) : 40'd0;
        desc.last_step = '0;
        known          = 1'b1;
        unique case (host_item.kind)
            KIND_CMD:    desc.last_step = '0;
            KIND_DATA:   desc.last_step = '0;
            KIND_CHAR:   desc.last_step = printable ? CHAR_LAST_STEP : '0;
            KIND_SETPOS:
            begin
                desc.last_step = STEP_W'(1);
                desc.data      = x_clamped;
            end
            KIND_INIT:   desc.last_step = STEP_W'(5);
            default:     known = 1'b0;
        endcase
    end

    assign push = host_valid && !q_full && known;

endmodule

`default_nettype wire

// ----- hdl/lcdtb_queue.sv -----
`default_nettype none

module lcdtb_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire lcdtb_pkg::desc_t wr_desc,
    input  wire logic             pop,
    output logic                  full,
    output logic                  head_valid,
    output lcdtb_pkg::desc_t      head
);
    import lcdtb_pkg::*;

    desc_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_next;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/lcdtb_back.sv -----
`default_nettype none

module lcdtb_back
#(
    parameter int COLUMNS     = lcdtb_pkg::COLUMNS_DEF,
    parameter int BANKS       = lcdtb_pkg::BANKS_DEF,
    parameter int GLYPH_WIDTH = lcdtb_pkg::GLYPH_WIDTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head_valid,
    input  wire lcdtb_pkg::desc_t head,
    input  wire lcdtb_pkg::cfg_t  cfg,
    output logic                  pop,
    output logic                  lcd_valid,
    input  wire logic             lcd_stall,
    output lcdtb_pkg::out_item_t  lcd_item
);
    import lcdtb_pkg::*;

    localparam logic [6:0] LAST_COL  = 7'(COLUMNS - 1);
    localparam logic [2:0] LAST_BANK = 3'(BANKS - 1);
    localparam logic [STEP_W-1:0] GW = STEP_W'(GLYPH_WIDTH);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [6:0]        col_reg;
    logic [6:0]        col_next;
    logic [2:0]        bank_reg;
    logic [2:0]        bank_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_item_reg;
    out_item_t         out_item_next;

    logic       fire;
    logic       last_byte;
    logic       is_data;
    logic [7:0] byte_val;
    logic [6:0] adv_col;
    logic [2:0] adv_bank;

    assign fire      = head_valid && (!out_valid_reg || !lcd_stall);
    assign last_byte = (step_reg == head.last_step);
    assign pop       = fire && last_byte;
    assign lcd_valid = out_valid_reg;
    assign lcd_item  = out_item_reg;

    // Cursor after one data byte
    always_comb
    begin
        adv_col  = col_reg + 1'b1;
        adv_bank = bank_reg;
        if (col_reg >= LAST_COL)
        begin
            adv_col  = '0;
            adv_bank = (bank_reg >= LAST_BANK) ? 3'd0 : bank_reg + 1'b1;
        end
    end

    always_comb
    begin
        is_data   = 1'b0;
        byte_val  = 8'h00;
        col_next  = col_reg;
        bank_next = bank_reg;
        unique case (head.kind)
            KIND_CMD:  byte_val = head.data;
            KIND_DATA:
            begin
                is_data  = 1'b1;
                byte_val = head.data;
            end
            KIND_CHAR:
            begin
                is_data  = 1'b1;
                byte_val = (step_reg < GW) ? glyph_col(head.glyph, step_reg) : 8'h00;
            end
            KIND_SETPOS:
            begin
                if (step_reg == '0)
                begin
                    byte_val = CMD_SET_X + head.data;
                    col_next = head.data[6:0];
                end
                else
                begin
                    byte_val  = CMD_SET_Y + {5'd0, head.bank};
                    bank_next = head.bank;
                end
            end
            KIND_INIT:
            begin
                case (step_reg)
                    4'd0:    byte_val = CMD_EXTENDED;
                    4'd1:    byte_val = cfg.contrast;
                    4'd2:    byte_val = {5'd0, cfg.temp_coeff};
                    4'd3:    byte_val = {3'd0, cfg.bias};
                    4'd4:    byte_val = CMD_BASIC;
                    default: byte_val = CMD_NORMAL;
                endcase
            end
            default:   byte_val = 8'h00;
        endcase
        if (is_data)
        begin
            col_next  = adv_col;
            bank_next = adv_bank;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (fire)
        begin
            out_valid_next         = 1'b1;
            out_item_next.is_data  = is_data;
            out_item_next.out_byte = byte_val;
            out_item_next.last     = last_byte;
            out_item_next.cursor_x = col_next;
            out_item_next.cursor_y = bank_next;
        end
        else if (!lcd_stall)
        begin
            out_valid_next = 1'b0;
        end
        step_next = step_reg;
        if (fire)
        begin
            step_next = last_byte ? '0 : step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            col_reg       <= '0;
            bank_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            col_reg       <= fire ? col_next : col_reg;
            bank_reg      <= fire ? bank_next : bank_reg;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/lcd_text_byte_generator_core.sv -----
// Channel   Dir  Handshake            Payload
// host      in   host_valid/stall     in_item_t: kind, value, pos_x, pos_y
// lcd       out  lcd_valid/stall      out_item_t: is_data, out_byte, last, cursor
// config    in   APB psel/penable     contrast, temp_coeff, bias at 0x0/0x4/0x8
//
// The back end sequencer sends one byte per cycle when not stalled: a printable
// character gives GLYPH_WIDTH+1 bytes, init 6, set position 2, command or data 1.
// A two-entry queue lets the host side keep transferring while bytes drain.
// Reset clears cursor, queue and output valid; registers go to their defaults.
// lcd_stall holds the output register; the queue fills and then host_stall rises.
`default_nettype none

module lcd_text_byte_generator_core
#(
    parameter int COLUMNS     = lcdtb_pkg::COLUMNS_DEF,
    parameter int BANKS       = lcdtb_pkg::BANKS_DEF,
    parameter int GLYPH_WIDTH = lcdtb_pkg::GLYPH_WIDTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          host_valid,
    output logic                               host_stall,
    input  wire lcdtb_pkg::in_item_t           host_item,
    output logic                               lcd_valid,
    input  wire logic                          lcd_stall,
    output lcdtb_pkg::out_item_t               lcd_item,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lcdtb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);
    import lcdtb_pkg::*;

    cfg_t  cfg;
    desc_t wr_desc;
    desc_t head;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  head_valid;

    lcdtb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcdtb_front
    #(
        .COLUMNS     (COLUMNS),
        .BANKS       (BANKS),
        .GLYPH_WIDTH (GLYPH_WIDTH)
    )
    u_front
    (
        .host_valid (host_valid),
        .host_item  (host_item),
        .q_full     (q_full),
        .host_stall (host_stall),
        .push       (push),
        .desc       (wr_desc)
    );

    lcdtb_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_desc    (wr_desc),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    lcdtb_back
    #(
        .COLUMNS     (COLUMNS),
        .BANKS       (BANKS),
        .GLYPH_WIDTH (GLYPH_WIDTH)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .cfg        (cfg),
        .pop        (pop),
        .lcd_valid  (lcd_valid),
        .lcd_stall  (lcd_stall),
        .lcd_item   (lcd_item)
    );

endmodule

`default_nettype wire

// ----- hdl/lcdtb_checker.sv -----
`default_nettype none

module lcdtb_checker
#(
    parameter int COLUMNS = lcdtb_pkg::COLUMNS_DEF,
    parameter int BANKS   = lcdtb_pkg::BANKS_DEF
)
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 lcd_valid,
    input wire logic                 lcd_stall,
    input wire lcdtb_pkg::out_item_t lcd_item
);
    import lcdtb_pkg::*;

    logic xfer_data;

    assign xfer_data = lcd_valid && !lcd_stall && lcd_item.is_data;

    // Stalled transfer holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        lcd_valid && lcd_stall |=> lcd_valid && $stable(lcd_item))
        else $error("lcd output changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        lcd_valid |-> (32'(lcd_item.cursor_x) < COLUMNS) && (32'(lcd_item.cursor_y) < BANKS))
        else $error("cursor out of range");

    // Back-to-back data bytes step the cursor by one column or wrap
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        xfer_data ##1 xfer_data |->
            ({1'b0, lcd_item.cursor_x} == {1'b0, $past(lcd_item.cursor_x)} + 8'd1) ||
            (lcd_item.cursor_x == 7'd0))
        else $error("cursor did not advance on data byte");

endmodule

bind lcd_text_byte_generator_core lcdtb_checker
#(
    .COLUMNS (COLUMNS),
    .BANKS   (BANKS)
)
u_lcdtb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .lcd_valid (lcd_valid),
    .lcd_stall (lcd_stall),
    .lcd_item  (lcd_item)
);

`default_nettype wire
